// ===== hw/rtl/ksm_pkg.sv =====
// ----------------------------------------------------------------------------
// ksm_pkg: shared types and codes for the k-way sorted merge core
// Item structs for both channels, command and status codes, and the
// control/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ksm_pkg;

    // Fixed field widths of the channel items
    localparam int IDX_W   = 3;
    localparam int FIELD_W = 16;

    // Command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_DROP  = 2'd2;

    // Input item
    typedef struct packed {
        logic                      command;
        logic [IDX_W-1:0]          list_index;
        logic signed [FIELD_W-1:0] value;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic signed [FIELD_W-1:0] result_value;
        logic [1:0]                status;
        logic                      was_last;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;     // execute the item on the input port this cycle
        logic refill;   // load the fetched head into the head register
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic refill_needed;   // the pop being executed leaves its list non-empty
    } dp_status_t;

endpackage

// ===== hw/rtl/ksm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ksm_ctrl: sequencer of the k-way sorted merge core
// Handles both handshakes, issues execute and refill commands and owns the
// valid bit of the result register.
// ----------------------------------------------------------------------------
module ksm_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output ksm_pkg::ctrl_cmd_t  cmd,
    input  ksm_pkg::dp_status_t stat
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_REFILL = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   accept;

    // Take an item when idle and the result register is free or draining
    assign cmd_stall = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = cmd_valid && !cmd_stall;

    assign cmd.exec   = accept;
    assign cmd.refill = (state_reg == S_REFILL);
    assign rsp_valid  = rsp_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && stat.refill_needed)
                begin
                    state_next = S_REFILL;
                end
            end
            S_REFILL:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid: set on execute, cleared when taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Refill state lasts exactly one cycle
    a_refill_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_REFILL |=> state_reg == S_IDLE)
        else $error("refill state held longer than one cycle");

    // Refill only follows an accepted pop that left its list non-empty
    a_refill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_REFILL |-> $past(accept && stat.refill_needed))
        else $error("refill entered without a pop needing it");

    // No item taken while a head refill is pending
    a_no_accept_refill: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_REFILL |-> cmd_stall)
        else $error("item accepted during refill");

    // A new result only appears after an accepted item
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(accept))
        else $error("result valid without an accepted item");

endmodule

// ===== hw/rtl/ksm_datapath.sv =====
// ----------------------------------------------------------------------------
// ksm_datapath: list storage, head registers and minimum search
// Per-list circular FIFOs share one memory; each list's head is mirrored in
// a register so a pop compares all heads through a comparator tree.
// ----------------------------------------------------------------------------
module ksm_datapath #(
    parameter int LISTS      = 8,
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ksm_pkg::ctrl_cmd_t   cmd,
    output ksm_pkg::dp_status_t  stat,
    input  ksm_pkg::in_item_t    in_item,
    output ksm_pkg::out_item_t   out_item
);

    localparam int LB        = $clog2(LISTS);
    localparam int LEAVES    = 1 << LB;
    localparam int NODES     = 2 * LEAVES;
    localparam int PTR_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int SUM_BITS  = CNT_BITS + 1;
    localparam int MEM_WORDS = LISTS * (1 << PTR_BITS);
    localparam int XIDX_BITS = LB + ksm_pkg::IDX_W;

    // List storage, read data and head state
    logic [VALUE_BITS-1:0] mem [MEM_WORDS];
    logic [VALUE_BITS-1:0] rd_reg;
    logic [VALUE_BITS-1:0] head_reg [LISTS];
    logic [PTR_BITS-1:0]   rp_reg [LISTS];
    logic [CNT_BITS-1:0]   fill_reg [LISTS];
    logic [LB-1:0]         refill_list_reg;
    ksm_pkg::out_item_t    result_reg;
    ksm_pkg::out_item_t    result_next;

    // Comparator tree nodes, heap layout, root at 1
    logic                  node_v [NODES];
    logic [VALUE_BITS-1:0] node_k [NODES];
    logic [LB-1:0]         node_i [NODES];

    logic [LISTS-1:0]      nonempty;
    logic [LISTS-1:0]      best_oh;
    logic                  found;
    logic [LB-1:0]         best;
    logic [PTR_BITS-1:0]   best_rp_next;
    logic                  was_last;

    logic [XIDX_BITS-1:0]  idx_wide;
    logic [LB-1:0]         push_list;
    logic                  push_in_range;
    logic                  push_full;
    logic                  push_ok;
    logic [SUM_BITS-1:0]   tail_sum;
    logic [PTR_BITS-1:0]   tail_pos;
    logic signed [63:0]    push_wide;
    logic [VALUE_BITS-1:0] push_val;
    logic signed [63:0]    pop_wide;

    logic                  is_push;
    logic                  is_pop;
    logic                  do_push;
    logic                  do_pop;
    logic                  do_read;

    // Non-empty flags
    always_comb
    begin
        for (int i = 0; i < LISTS; i++)
        begin
            nonempty[i] = (fill_reg[i] != '0);
        end
    end

    // Minimum over the heads; on a tie the left (lower index) side wins
    always_comb
    begin
        node_v[0] = 1'b0;
        node_k[0] = '0;
        node_i[0] = '0;
        for (int n = 0; n < LEAVES; n++)
        begin
            if (n < LISTS)
            begin
                node_v[LEAVES + n] = nonempty[n];
                node_k[LEAVES + n] = head_reg[n];
            end
            else
            begin
                node_v[LEAVES + n] = 1'b0;
                node_k[LEAVES + n] = '0;
            end
            node_i[LEAVES + n] = LB'(n);
        end
        for (int n = LEAVES - 1; n >= 1; n--)
        begin
            if (node_v[2*n] && (!node_v[2*n+1] ||
                ($signed(node_k[2*n]) <= $signed(node_k[2*n+1]))))
            begin
                node_v[n] = 1'b1;
                node_k[n] = node_k[2*n];
                node_i[n] = node_i[2*n];
            end
            else
            begin
                node_v[n] = node_v[2*n+1];
                node_k[n] = node_k[2*n+1];
                node_i[n] = node_i[2*n+1];
            end
        end
    end

    assign found = node_v[1];
    assign best  = node_i[1];

    // Pop bookkeeping
    assign best_oh      = LISTS'(1) << best;
    assign best_rp_next = (rp_reg[best] == PTR_BITS'(DEPTH - 1)) ? '0 : rp_reg[best] + 1'b1;
    assign was_last     = (fill_reg[best] == CNT_BITS'(1)) && ((nonempty & ~best_oh) == '0);
    assign pop_wide     = 64'($signed(head_reg[best]));

    // Push bookkeeping
    assign idx_wide      = XIDX_BITS'(in_item.list_index);
    assign push_list     = idx_wide[LB-1:0];
    assign push_in_range = (idx_wide < XIDX_BITS'(LISTS));
    assign push_full     = (fill_reg[push_list] == CNT_BITS'(DEPTH));
    assign push_ok       = push_in_range && !push_full;
    assign tail_sum      = SUM_BITS'(rp_reg[push_list]) + SUM_BITS'(fill_reg[push_list]);
    assign tail_pos      = (tail_sum >= SUM_BITS'(DEPTH)) ?
                           PTR_BITS'(tail_sum - SUM_BITS'(DEPTH)) : PTR_BITS'(tail_sum);
    assign push_wide     = 64'($signed(in_item.value));
    assign push_val      = push_wide[VALUE_BITS-1:0];

    // Command decode
    assign is_push = (in_item.command == ksm_pkg::CMD_PUSH);
    assign is_pop  = (in_item.command == ksm_pkg::CMD_POP);
    assign do_push = cmd.exec && is_push && push_ok;
    assign do_pop  = cmd.exec && is_pop && found;
    assign do_read = do_pop && (fill_reg[best] > CNT_BITS'(1));

    assign stat.refill_needed = is_pop && found && (fill_reg[best] > CNT_BITS'(1));
    assign out_item           = result_reg;

    // Result of the item on the input port
    always_comb
    begin
        result_next        = '0;
        result_next.status = ksm_pkg::STAT_OK;
        if (is_push)
        begin
            if (!push_ok)
            begin
                result_next.status = ksm_pkg::STAT_DROP;
            end
        end
        else if (!found)
        begin
            result_next.status = ksm_pkg::STAT_EMPTY;
        end
        else
        begin
            result_next.result_value = pop_wide[ksm_pkg::FIELD_W-1:0];
            result_next.was_last     = was_last;
        end
    end

    // List memory: push writes the tail, pop fetches the next head
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[{push_list, tail_pos}] <= push_val;
        end
        if (do_read)
        begin
            rd_reg <= mem[{best, best_rp_next}];
        end
    end

    // Pointers and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LISTS; i++)
            begin
                rp_reg[i]   <= '0;
                fill_reg[i] <= '0;
            end
        end
        else if (do_push)
        begin
            fill_reg[push_list] <= fill_reg[push_list] + 1'b1;
        end
        else if (do_pop)
        begin
            rp_reg[best]   <= best_rp_next;
            fill_reg[best] <= fill_reg[best] - 1'b1;
        end
    end

    // Head registers, refill target and result register
    always_ff @(posedge clk)
    begin
        if (do_push && !nonempty[push_list])
        begin
            head_reg[push_list] <= push_val;
        end
        else if (cmd.refill)
        begin
            head_reg[refill_list_reg] <= rd_reg;
        end
        if (do_pop)
        begin
            refill_list_reg <= best;
        end
        if (cmd.exec)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== hw/rtl/k_way_sorted_merge_core.sv =====
// ----------------------------------------------------------------------------
// Result: an item's result is registered in the cycle after it is accepted.
// Input: a push lets the next item in unless the result is held; a pop that
// leaves its list non-empty is followed by a refill state that takes no item
// and loads the new head from the list memory's registered read port.
// Reset: fill counts and read pointers clear at once, so all lists are empty;
// the list memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// k_way_sorted_merge_core: k-way merge of ascending lists
// Push appends to a named list FIFO, pop removes the smallest head with the
// lowest list index winning ties.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_core #(
    parameter int LISTS      = 8,
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  ksm_pkg::in_item_t  cmd_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output ksm_pkg::out_item_t rsp_item
);

    ksm_pkg::ctrl_cmd_t  cmd;
    ksm_pkg::dp_status_t stat;

    // Sequencer
    ksm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Storage and compare datapath
    ksm_datapath #(
        .LISTS      (LISTS),
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_item  (cmd_item),
        .out_item (rsp_item)
    );

endmodule
